### rtl/atbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package atbp_pkg;

  localparam int VRAM_BYTES = 131072;
  localparam int VRAM_AW    = $clog2(VRAM_BYTES);
  localparam int LINE_WIDTH = 240;

  localparam int CFG_DW  = 28;
  localparam int CFG_IW  = 3;
  localparam int ADDR_W  = 17;

  // map block stride 0x800, tile block stride 0x4000, tile size 0x40
  localparam int MAP_BLOCK_SHIFT  = 11;
  localparam int TILE_BLOCK_SHIFT = 14;
  localparam int TILE_SHIFT       = 6;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IW-1:0] {
    REG_REF_X      = 3'd0,
    REG_REF_Y      = 3'd1,
    REG_COEF_A     = 3'd2,
    REG_COEF_B     = 3'd3,
    REG_COEF_C     = 3'd4,
    REG_COEF_D     = 3'd5,
    REG_LAYER_CTRL = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_WRITE    = 2'd0,
    KIND_PIXEL    = 2'd1,
    KIND_BACKDROP = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [VRAM_AW-1:0] addr;        // write address or map entry address
    logic [7:0]         data;
    logic [7:0]         pixel_x;
    logic [5:0]         texel;       // {row, col} inside the tile
    logic [1:0]         tile_block;
  } job_t;

  typedef struct packed {
    logic           full;
    logic           valid;
    logic [QCW-1:0] count;
  } q_status_t;

endpackage

`default_nettype wire

### rtl/atbp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module atbp_front
  import atbp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_req_type,
  input  wire logic [ADDR_W-1:0] in_mem_addr,
  input  wire logic [7:0]        in_mem_byte,
  input  wire logic [7:0]        in_screen_x,
  input  wire logic [7:0]        in_screen_y,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_wdata,
  input  wire q_status_t         q_stat,
  output logic                   push,
  output job_t                   push_job
);

  logic [27:0] ref_x_r, ref_y_r;
  logic signed [15:0] coef_a_r, coef_b_r, coef_c_r, coef_d_r;
  logic [9:0]  layer_ctrl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_x_r      <= '0;
      ref_y_r      <= '0;
      coef_a_r     <= 16'sd256;
      coef_b_r     <= '0;
      coef_c_r     <= '0;
      coef_d_r     <= 16'sd256;
      layer_ctrl_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REF_X:      ref_x_r      <= cfg_wdata[27:0];
        REG_REF_Y:      ref_y_r      <= cfg_wdata[27:0];
        REG_COEF_A:     coef_a_r     <= cfg_wdata[15:0];
        REG_COEF_B:     coef_b_r     <= cfg_wdata[15:0];
        REG_COEF_C:     coef_c_r     <= cfg_wdata[15:0];
        REG_COEF_D:     coef_d_r     <= cfg_wdata[15:0];
        REG_LAYER_CTRL: layer_ctrl_r <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // Whole front advances together; stalls only when the last stage can't push.
  logic f1_valid_r, f2_valid_r, f3_valid_r;
  logic en_f;

  assign en_f     = !f3_valid_r || !q_stat.full;
  assign in_ready = en_f;
  assign push     = f3_valid_r && !q_stat.full;

  // accept stage: drop writes beyond memory and columns beyond the line
  logic  acc_keep_nxt;
  kind_t acc_kind_nxt;

  always_comb begin
    if (!in_req_type) begin
      acc_kind_nxt = KIND_WRITE;
      acc_keep_nxt = 18'(in_mem_addr) < 18'(VRAM_BYTES);
    end else begin
      acc_kind_nxt = KIND_PIXEL;
      acc_keep_nxt = 11'(in_screen_x) < 11'(LINE_WIDTH);
    end
  end

  kind_t              f1_kind_r, f2_kind_r, f3_kind_r;
  logic [VRAM_AW-1:0] f1_addr_r, f2_addr_r, f3_addr_r;
  logic [7:0]         f1_data_r, f2_data_r, f3_data_r;
  logic [7:0]         f1_sx_r, f2_sx_r, f3_sx_r;
  logic [7:0]         f1_sy_r;

  logic signed [24:0] f2_pxa_r, f2_pyb_r, f2_pxc_r, f2_pyd_r;
  logic signed [24:0] pxa_nxt, pyb_nxt, pxc_nxt, pyd_nxt;
  logic [29:0]        sum_x_nxt, sum_y_nxt;
  logic [21:0]        f3_tx_r, f3_ty_r;

  assign pxa_nxt = $signed({1'b0, f1_sx_r}) * coef_a_r;
  assign pyb_nxt = $signed({1'b0, f1_sy_r}) * coef_b_r;
  assign pxc_nxt = $signed({1'b0, f1_sx_r}) * coef_c_r;
  assign pyd_nxt = $signed({1'b0, f1_sy_r}) * coef_d_r;

  // two's complement sums; dropping the low 8 bits is the floor shift
  assign sum_x_nxt = {{5{f2_pxa_r[24]}}, f2_pxa_r} + {{5{f2_pyb_r[24]}}, f2_pyb_r}
                   + {{2{ref_x_r[27]}}, ref_x_r};
  assign sum_y_nxt = {{5{f2_pxc_r[24]}}, f2_pxc_r} + {{5{f2_pyd_r[24]}}, f2_pyd_r}
                   + {{2{ref_y_r[27]}}, ref_y_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
      f3_valid_r <= 1'b0;
    end else if (en_f) begin
      f1_valid_r <= in_valid && acc_keep_nxt;
      f2_valid_r <= f1_valid_r;
      f3_valid_r <= f2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_f) begin
      f1_kind_r <= acc_kind_nxt;
      f1_addr_r <= VRAM_AW'(in_mem_addr);
      f1_data_r <= in_mem_byte;
      f1_sx_r   <= in_screen_x;
      f1_sy_r   <= in_screen_y;

      f2_kind_r <= f1_kind_r;
      f2_addr_r <= f1_addr_r;
      f2_data_r <= f1_data_r;
      f2_sx_r   <= f1_sx_r;
      f2_pxa_r  <= pxa_nxt;
      f2_pyb_r  <= pyb_nxt;
      f2_pxc_r  <= pxc_nxt;
      f2_pyd_r  <= pyd_nxt;

      f3_kind_r <= f2_kind_r;
      f3_addr_r <= f2_addr_r;
      f3_data_r <= f2_data_r;
      f3_sx_r   <= f2_sx_r;
      f3_tx_r   <= sum_x_nxt[29:8];
      f3_ty_r   <= sum_y_nxt[29:8];
    end
  end

  // classify and form the map entry address
  logic [1:0]  size_sel;
  logic [3:0]  size_log;
  logic [9:0]  coord_mask, ux, uy;
  logic        outside;
  logic [17:0] map_sum, map_red;

  assign size_sel   = layer_ctrl_r[1:0];
  assign size_log   = 4'd7 + {2'b00, size_sel};
  assign coord_mask = ~(10'h3FF << size_log);
  assign outside    = f3_tx_r[21] || f3_ty_r[21]
                   || ((f3_tx_r[20:0] >> size_log) != '0)
                   || ((f3_ty_r[20:0] >> size_log) != '0);
  assign ux         = f3_tx_r[9:0] & coord_mask;
  assign uy         = f3_ty_r[9:0] & coord_mask;

  assign map_sum = (18'(layer_ctrl_r[7:3]) << MAP_BLOCK_SHIFT)
                 + (18'(uy[9:3]) << (3'd4 + {1'b0, size_sel}))
                 + 18'(ux[9:3]);
  // sum stays below twice the memory size
  assign map_red = (map_sum >= 18'(VRAM_BYTES)) ? map_sum - 18'(VRAM_BYTES) : map_sum;

  always_comb begin
    push_job.pixel_x    = f3_sx_r;
    push_job.data       = f3_data_r;
    push_job.texel      = {uy[2:0], ux[2:0]};
    push_job.tile_block = layer_ctrl_r[9:8];
    case (f3_kind_r)
      KIND_WRITE: begin
        push_job.kind = KIND_WRITE;
        push_job.addr = f3_addr_r;
      end
      default: begin
        push_job.kind = (outside && !layer_ctrl_r[2]) ? KIND_BACKDROP : KIND_PIXEL;
        push_job.addr = VRAM_AW'(map_red);
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/atbp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module atbp_queue
  import atbp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      pop_job,
  output q_status_t q_stat
);

  job_t           slot_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_job;
  end

  assign pop_job      = slot_r[rd_ptr_r];
  assign q_stat.full  = count_r == QCW'(QDEPTH);
  assign q_stat.valid = count_r != '0;
  assign q_stat.count = count_r;

endmodule

`default_nettype wire

### rtl/atbp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module atbp_back
  import atbp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire q_status_t  q_stat,
  input  wire job_t       q_job,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_pixel_x,
  output logic [7:0]      out_color_index,
  output logic            out_is_backdrop
);

  logic [7:0] vram_mem [VRAM_BYTES];

  logic en_b;
  logic b1_valid_r, b2_valid_r, out_valid_r;
  job_t b1_job_r;

  kind_t      b2_kind_r;
  logic [7:0] b2_pixel_x_r, b2_tile_num_r;
  logic [5:0] b2_texel_r;
  logic [1:0] b2_tile_block_r;

  logic [7:0] out_pixel_x_r, out_color_r;
  logic       out_backdrop_r;

  logic [15:0] tile_addr;

  assign en_b = !out_valid_r || out_ready;
  assign pop  = en_b && q_stat.valid;

  // block base, tile base and texel offset never overlap, so this is a concatenation
  assign tile_addr = {b2_tile_block_r, b2_tile_num_r, b2_texel_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      b2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en_b) begin
      b1_valid_r  <= q_stat.valid;
      b2_valid_r  <= b1_valid_r && (b1_job_r.kind != KIND_WRITE);
      out_valid_r <= b2_valid_r;
    end
  end

  // A write commits on the same edge as the tile read of the item ahead of it,
  // so that item still sees the old byte while every later map read sees the new one.
  always_ff @(posedge clk) begin
    if (en_b) begin
      if (q_stat.valid) b1_job_r <= q_job;

      if (b1_valid_r && (b1_job_r.kind == KIND_WRITE)) begin
        vram_mem[b1_job_r.addr] <= b1_job_r.data;
      end
      if (b1_valid_r && (b1_job_r.kind == KIND_PIXEL)) begin
        b2_tile_num_r <= vram_mem[b1_job_r.addr];
      end
      b2_kind_r       <= b1_job_r.kind;
      b2_pixel_x_r    <= b1_job_r.pixel_x;
      b2_texel_r      <= b1_job_r.texel;
      b2_tile_block_r <= b1_job_r.tile_block;

      out_pixel_x_r <= b2_pixel_x_r;
      case (b2_kind_r)
        KIND_PIXEL: begin
          out_color_r    <= vram_mem[VRAM_AW'(tile_addr)];
          out_backdrop_r <= 1'b0;
        end
        default: begin
          out_color_r    <= '0;
          out_backdrop_r <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = out_pixel_x_r;
  assign out_color_index = out_color_r;
  assign out_is_backdrop = out_backdrop_r;

endmodule

`default_nettype wire

### rtl/affine_tile_background_pixel_top.sv
// Affine tiled background layer, one pixel per transaction.
// Input channel (in_valid/in_ready): in_req_type 0 writes in_mem_byte to video
// memory at in_mem_addr and gives no result; 1 renders the pixel at
// (in_screen_x, in_screen_y). Columns beyond the line give no result.
// Output channel (out_valid/out_ready): one result per rendered pixel, in order:
// column, palette index and backdrop flag.
// Config port: cfg_we writes cfg_wdata into register cfg_index at the clock edge;
// write only while the block is empty.
// A result passes front stages f1, f2, f3, the queue, back stages b1, b2 and the output register.
// Throughput: one transaction per cycle while in_ready stays high, set by the two read ports of video
// memory (map entry read, then tile byte read one stage later).
// Reset (rst_n low, synchronous): registers return to their defaults and all
// stages and the 4-entry queue are emptied; video memory is not cleared.
// When the receiver stalls, the output register holds, the back end stops,
// the queue fills, and then in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module affine_tile_background_pixel_top
  import atbp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_req_type,
  input  wire logic [ADDR_W-1:0] in_mem_addr,
  input  wire logic [7:0]        in_mem_byte,
  input  wire logic [7:0]        in_screen_x,
  input  wire logic [7:0]        in_screen_y,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_pixel_x,
  output logic [7:0]             out_color_index,
  output logic                   out_is_backdrop,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_wdata
);

  logic      push, pop;
  job_t      push_job, pop_job;
  q_status_t q_stat;

  atbp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_mem_addr (in_mem_addr),
    .in_mem_byte (in_mem_byte),
    .in_screen_x (in_screen_x),
    .in_screen_y (in_screen_y),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .q_stat      (q_stat),
    .push        (push),
    .push_job    (push_job)
  );

  atbp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_stat   (q_stat)
  );

  atbp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .q_job           (pop_job),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_x     (out_pixel_x),
    .out_color_index (out_color_index),
    .out_is_backdrop (out_is_backdrop)
  );

`ifndef ASSERT_OFF
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= QCW'(QDEPTH))
    else $error("queue occupancy beyond depth");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_stat.valid)
    else $error("pop from empty queue");

  a_backdrop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_backdrop) |-> (out_color_index == 8'd0))
    else $error("backdrop pixel with nonzero color");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire
